// ----- design/bpa_pkg.sv -----
package bpa_pkg;

    localparam int POOL_PAGES_DEF = 4096;
    localparam int TOP_RANK_DEF   = 16;

    localparam int RANK_W = 5;
    localparam int ENTRY_W = RANK_W + 1;   // page entry: {taken, rank}

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_ALLOC = 3'd1;
    localparam logic [2:0] OP_FREE  = 3'd2;
    localparam logic [2:0] OP_QRANK = 3'd3;
    localparam logic [2:0] OP_QCNT  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

endpackage

// ----- design/bpa_ram.sv -----
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- design/buddy_page_allocator.sv -----
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------
// request   | i_in_valid / o_in_ready    | i_operation, i_rank, i_page
// response  | o_out_valid / i_out_ready  | o_status, o_block_page, o_answer
// config    | i_cfg_we (no wait)         | i_cfg_data (pool_pages)
//
// One request at a time; o_in_ready is high only while the controller is idle.
// Init sweeps every page of the page RAM. Allocate and return rewrite the page RAM
// one page per cycle for every block they split or merge, and each merge walks a
// free list node by node. After reset the same sweep clears the page RAM before
// the first transfer; config writes are taken throughout.
// A finished response waits in the output register; the next request is taken
// meanwhile, and its own response stalls until the register is free.
module buddy_page_allocator #(
    parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
    parameter int TOP_RANK   = bpa_pkg::TOP_RANK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [4:0]  i_rank,
    input  logic [15:0] i_page,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [11:0] o_block_page,
    output logic [12:0] o_answer
);

    localparam int AW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int SW = AW + 1;
    localparam int EW = bpa_pkg::ENTRY_W;
    localparam logic [SW-1:0] POOL_SZ   = SW'(POOL_PAGES);
    localparam logic [AW-1:0] LAST_PAGE = AW'(POOL_PAGES - 1);
    localparam logic [4:0]    TOP_R     = 5'(TOP_RANK);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SWEEP    = 4'd1;
    localparam logic [3:0] S_SPLIT    = 4'd2;
    localparam logic [3:0] S_SPLIT_W  = 4'd3;
    localparam logic [3:0] S_SPLIT_W2 = 4'd4;
    localparam logic [3:0] S_POP      = 4'd5;
    localparam logic [3:0] S_POP_W    = 4'd6;
    localparam logic [3:0] S_FILL     = 4'd7;
    localparam logic [3:0] S_RET_CHK  = 4'd8;
    localparam logic [3:0] S_MERGE    = 4'd9;
    localparam logic [3:0] S_MERGE_W  = 4'd10;
    localparam logic [3:0] S_WALK     = 4'd11;
    localparam logic [3:0] S_WALK_W   = 4'd12;
    localparam logic [3:0] S_PUSH     = 4'd13;
    localparam logic [3:0] S_QUERY    = 4'd14;
    localparam logic [3:0] S_RESULT   = 4'd15;

    // Pages in a block of rank r; ranks of real blocks always fit SW bits.
    function automatic logic [SW-1:0] blk_len(input logic [4:0] r);
        blk_len = SW'(1) << (r - 5'd1);
    endfunction

    // Largest rank whose block fits in rem pages, capped at the top rank.
    function automatic logic [4:0] fit_rank(input logic [SW-1:0] rem);
        logic [4:0] m;
        m = '0;
        for (int i = 0; i < SW; i++) begin
            if (rem[i]) m = 5'(i + 1);
        end
        if (m > TOP_R) m = TOP_R;
        return m;
    endfunction

    // Control and list state
    logic [3:0]    r_state, n_state;
    logic [3:0]    r_fnext, n_fnext;
    logic [12:0]   r_pool_pages;
    logic [SW-1:0] r_pool_size, n_pool_size;
    logic [AW-1:0] r_head  [TOP_RANK+1];
    logic [AW-1:0] n_head  [TOP_RANK+1];
    logic [SW-1:0] r_count [TOP_RANK+1];
    logic [SW-1:0] n_count [TOP_RANK+1];
    logic          r_init, n_init;
    logic [AW-1:0] r_p, n_p;
    logic [SW-1:0] r_bend, n_bend;
    logic [4:0]    r_brank, n_brank;

    // Working registers of one request
    logic [4:0]    r_rank, n_rank;
    logic [4:0]    r_cur, n_cur;
    logic [4:0]    r_r, n_r;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_node, n_node;
    logic [AW-1:0] r_prev, n_prev;
    logic [AW-1:0] r_buddy, n_buddy;
    logic [SW-1:0] r_k, n_k;
    logic [AW-1:0] r_fp, n_fp;
    logic [SW-1:0] r_fend, n_fend;
    logic [EW-1:0] r_fval, n_fval;

    // Pending and registered response
    logic [1:0]    r_res_status, n_res_status;
    logic [11:0]   r_res_bpage, n_res_bpage;
    logic [12:0]   r_res_answer, n_res_answer;
    logic          r_ov, n_ov;
    logic [1:0]    r_o_status, n_o_status;
    logic [11:0]   r_o_bpage, n_o_bpage;
    logic [12:0]   r_o_answer, n_o_answer;

    // RAM ports
    logic          link_we;
    logic [AW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
    logic          page_we;
    logic [AW-1:0] page_waddr, page_raddr;
    logic [EW-1:0] page_wdata, page_rdata;

    bpa_ram #(.WIDTH(AW), .DEPTH(POOL_PAGES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    bpa_ram #(.WIDTH(EW), .DEPTH(POOL_PAGES)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (page_we),
        .i_waddr (page_waddr),
        .i_wdata (page_wdata),
        .i_raddr (page_raddr),
        .o_rdata (page_rdata)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_status     = r_o_status;
    assign o_block_page = r_o_bpage;
    assign o_answer     = r_o_answer;

    always_comb begin
        logic          accept;
        logic          rank_ok;
        logic          page_ok;
        logic          found;
        logic [4:0]    fcur;
        logic [4:0]    lower;
        logic [4:0]    fr;
        logic [4:0]    er;
        logic [SW-1:0] half;
        logic [SW-1:0] buddy;
        logic [AW-1:0] ni;
        logic          pin;

        n_state      = r_state;
        n_fnext      = r_fnext;
        n_pool_size  = r_pool_size;
        n_head       = r_head;
        n_count      = r_count;
        n_init       = r_init;
        n_p          = r_p;
        n_bend       = r_bend;
        n_brank      = r_brank;
        n_rank       = r_rank;
        n_cur        = r_cur;
        n_r          = r_r;
        n_idx        = r_idx;
        n_node       = r_node;
        n_prev       = r_prev;
        n_buddy      = r_buddy;
        n_k          = r_k;
        n_fp         = r_fp;
        n_fend       = r_fend;
        n_fval       = r_fval;
        n_res_status = r_res_status;
        n_res_bpage  = r_res_bpage;
        n_res_answer = r_res_answer;
        n_o_status   = r_o_status;
        n_o_bpage    = r_o_bpage;
        n_o_answer   = r_o_answer;
        n_ov         = r_ov && !i_out_ready;

        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_raddr = '0;
        page_we    = 1'b0;
        page_waddr = '0;
        page_wdata = '0;
        page_raddr = '0;

        accept  = i_in_valid && (r_state == S_IDLE);
        rank_ok = (i_rank >= 5'd1) && (i_rank <= TOP_R);
        page_ok = ({1'b0, i_page} < 17'(r_pool_size));
        found   = 1'b0;
        fcur    = '0;
        for (int c = TOP_RANK; c >= 1; c--) begin
            if ((5'(c) >= i_rank) && (r_count[c] != '0)) begin
                found = 1'b1;
                fcur  = 5'(c);
            end
        end
        lower = r_cur - 5'd1;
        fr    = fit_rank(r_pool_size - {1'b0, r_p});
        er    = page_rdata[4:0];
        half  = '0;
        buddy = {1'b0, r_idx} ^ blk_len(r_r);
        ni    = (r_buddy < r_idx) ? r_buddy : r_idx;
        pin   = ({1'b0, r_p} < r_pool_size);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_status = bpa_pkg::ST_INVALID;
                    n_res_bpage  = '0;
                    n_res_answer = '0;
                    n_state      = S_RESULT;
                    unique case (i_operation)
                        bpa_pkg::OP_INIT: begin
                            n_pool_size = (32'(r_pool_pages) > 32'(POOL_PAGES)) ?
                                          POOL_SZ : SW'(r_pool_pages);
                            for (int c = 0; c <= TOP_RANK; c++) begin
                                n_head[c]  = '0;
                                n_count[c] = '0;
                            end
                            n_p     = '0;
                            n_bend  = '0;
                            n_brank = '0;
                            n_init  = 1'b1;
                            n_state = S_SWEEP;
                        end
                        bpa_pkg::OP_ALLOC: begin
                            if (rank_ok && !found) begin
                                n_res_status = bpa_pkg::ST_NOSPACE;
                            end else if (rank_ok) begin
                                n_rank  = i_rank;
                                n_cur   = fcur;
                                n_state = (fcur > i_rank) ? S_SPLIT : S_POP;
                            end
                        end
                        bpa_pkg::OP_FREE: begin
                            if (page_ok) begin
                                page_raddr = i_page[AW-1:0];
                                n_idx      = i_page[AW-1:0];
                                n_state    = S_RET_CHK;
                            end
                        end
                        bpa_pkg::OP_QRANK: begin
                            if (page_ok) begin
                                page_raddr = i_page[AW-1:0];
                                n_state    = S_QUERY;
                            end
                        end
                        bpa_pkg::OP_QCNT: begin
                            if (rank_ok) begin
                                n_res_status = bpa_pkg::ST_OK;
                                n_res_answer = 13'(r_count[i_rank]);
                            end
                        end
                        default: begin
                            n_res_status = bpa_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            // Walk every page: clear it, or stamp the rank of the carved block.
            S_SWEEP: begin
                page_we    = 1'b1;
                page_waddr = r_p;
                page_wdata = pin ? {1'b0, r_brank} : '0;
                if (pin && ({1'b0, r_p} == r_bend)) begin
                    link_we     = 1'b1;
                    link_waddr  = r_p;
                    link_wdata  = r_head[fr];
                    n_head[fr]  = r_p;
                    n_count[fr] = r_count[fr] + SW'(1);
                    n_brank     = fr;
                    n_bend      = {1'b0, r_p} + blk_len(fr);
                    page_wdata  = {1'b0, fr};
                end
                n_p = r_p + AW'(1);
                if (r_p == LAST_PAGE) begin
                    n_init = 1'b0;
                    if (r_init) begin
                        n_res_status = bpa_pkg::ST_OK;
                        n_res_bpage  = '0;
                        n_res_answer = '0;
                        n_state      = S_RESULT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SPLIT: begin
                link_raddr = r_head[r_cur];
                n_idx      = r_head[r_cur];
                n_state    = S_SPLIT_W;
            end
            // Pop the block and push its right half onto the lower list.
            S_SPLIT_W: begin
                n_head[r_cur]  = link_rdata;
                n_count[r_cur] = r_count[r_cur] - SW'(1);
                half           = blk_len(lower);
                link_we        = 1'b1;
                link_waddr     = AW'({1'b0, r_idx} + half);
                link_wdata     = r_head[lower];
                n_cur          = lower;
                n_state        = S_SPLIT_W2;
            end
            // Push the left half in front, then restamp the ranks of both halves.
            S_SPLIT_W2: begin
                half           = blk_len(r_cur);
                link_we        = 1'b1;
                link_waddr     = r_idx;
                link_wdata     = AW'({1'b0, r_idx} + half);
                n_head[r_cur]  = r_idx;
                n_count[r_cur] = r_count[r_cur] + SW'(2);
                n_fp           = r_idx;
                n_fend         = {1'b0, r_idx} + (half << 1);
                n_fval         = {1'b0, r_cur};
                n_fnext        = (r_cur > r_rank) ? S_SPLIT : S_POP;
                n_state        = S_FILL;
            end
            S_POP: begin
                link_raddr = r_head[r_rank];
                n_idx      = r_head[r_rank];
                n_state    = S_POP_W;
            end
            S_POP_W: begin
                n_head[r_rank]  = link_rdata;
                n_count[r_rank] = r_count[r_rank] - SW'(1);
                n_fp            = r_idx;
                n_fend          = {1'b0, r_idx} + blk_len(r_rank);
                n_fval          = {1'b1, r_rank};
                n_fnext         = S_RESULT;
                n_res_status    = bpa_pkg::ST_OK;
                n_res_bpage     = 12'(r_idx);
                n_res_answer    = '0;
                n_state         = S_FILL;
            end
            S_FILL: begin
                page_we    = 1'b1;
                page_waddr = r_fp;
                page_wdata = r_fval;
                n_fp       = r_fp + AW'(1);
                if (({1'b0, r_fp} + SW'(1)) == r_fend) begin
                    n_state = r_fnext;
                end
            end
            // Accept only the first page of a taken block.
            S_RET_CHK: begin
                if (page_rdata[EW-1] && (er >= 5'd1) && (er <= TOP_R) &&
                    (({1'b0, r_idx} & (blk_len(er) - SW'(1))) == '0)) begin
                    n_r     = er;
                    n_fp    = r_idx;
                    n_fend  = {1'b0, r_idx} + blk_len(er);
                    n_fval  = {1'b0, er};
                    n_fnext = S_MERGE;
                    n_state = S_FILL;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_MERGE: begin
                if ((r_r < TOP_R) && (buddy < r_pool_size)) begin
                    page_raddr = buddy[AW-1:0];
                    n_buddy    = buddy[AW-1:0];
                    n_state    = S_MERGE_W;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_MERGE_W: begin
                if (!page_rdata[EW-1] && (er == r_r)) begin
                    n_node  = r_head[r_r];
                    n_k     = '0;
                    n_state = S_WALK;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_WALK: begin
                if (r_k == r_count[r_r]) begin
                    n_state = S_PUSH;
                end else begin
                    link_raddr = r_node;
                    n_state    = S_WALK_W;
                end
            end
            // Unlink the buddy when found, else advance along the list.
            S_WALK_W: begin
                if (r_node == r_buddy) begin
                    if (r_k == '0) begin
                        n_head[r_r] = link_rdata;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = r_prev;
                        link_wdata = link_rdata;
                    end
                    n_count[r_r] = r_count[r_r] - SW'(1);
                    n_idx        = ni;
                    n_r          = r_r + 5'd1;
                    n_fp         = ni;
                    n_fend       = {1'b0, ni} + blk_len(r_r + 5'd1);
                    n_fval       = {1'b0, r_r + 5'd1};
                    n_fnext      = S_MERGE;
                    n_state      = S_FILL;
                end else begin
                    n_prev  = r_node;
                    n_node  = link_rdata;
                    n_k     = r_k + SW'(1);
                    n_state = S_WALK;
                end
            end
            S_PUSH: begin
                link_we      = 1'b1;
                link_waddr   = r_idx;
                link_wdata   = r_head[r_r];
                n_head[r_r]  = r_idx;
                n_count[r_r] = r_count[r_r] + SW'(1);
                n_res_status = bpa_pkg::ST_OK;
                n_res_bpage  = '0;
                n_res_answer = '0;
                n_state      = S_RESULT;
            end
            S_QUERY: begin
                n_res_status = bpa_pkg::ST_OK;
                n_res_bpage  = '0;
                n_res_answer = 13'(er);
                n_state      = S_RESULT;
            end
            // Hold the response until the output register is free.
            S_RESULT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_res_status;
                    n_o_bpage  = r_res_bpage;
                    n_o_answer = r_res_answer;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Reset runs the page sweep with an empty pool to clear the page RAM.
            r_state      <= S_SWEEP;
            r_pool_pages <= '0;
            r_pool_size  <= '0;
            r_init       <= 1'b0;
            r_p          <= '0;
            r_bend       <= '0;
            r_brank      <= '0;
            r_ov         <= 1'b0;
            for (int c = 0; c <= TOP_RANK; c++) begin
                r_head[c]  <= '0;
                r_count[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pool_size <= n_pool_size;
            r_init      <= n_init;
            r_p         <= n_p;
            r_bend      <= n_bend;
            r_brank     <= n_brank;
            r_ov        <= n_ov;
            r_head      <= n_head;
            r_count     <= n_count;
            if (i_cfg_we) begin
                r_pool_pages <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fnext      <= n_fnext;
        r_rank       <= n_rank;
        r_cur        <= n_cur;
        r_r          <= n_r;
        r_idx        <= n_idx;
        r_node       <= n_node;
        r_prev       <= n_prev;
        r_buddy      <= n_buddy;
        r_k          <= n_k;
        r_fp         <= n_fp;
        r_fend       <= n_fend;
        r_fval       <= n_fval;
        r_res_status <= n_res_status;
        r_res_bpage  <= n_res_bpage;
        r_res_answer <= n_res_answer;
        r_o_status   <= n_o_status;
        r_o_bpage    <= n_o_bpage;
        r_o_answer   <= n_o_answer;
    end

    // A list walk never runs past the length of the list.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_k <= r_count[r_r]))
        else $error("free list walk overran list length");

    // A rank restamp always has pages left to write.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> ({1'b0, r_fp} < r_fend))
        else $error("page fill ran past block end");

    // A new response only comes out of the result state.
    a_resp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == S_RESULT))
        else $error("response loaded outside result state");

endmodule
